[rtl/core/strc_pkg.sv]
// ----------------------------------------------------------------------------
// strc_pkg
// Shared types and constants of the skin tone range calibrator: field
// widths, stream packing, gray weights, tracker limits and register codes.
// ----------------------------------------------------------------------------
package strc_pkg;

   localparam int COORD_BITS = 12;
   localparam int PIXEL_BITS = 8;
   localparam int BOUND_BITS = 10;

   // Request tdata layout, lowest bits first.
   localparam int COL_LSB         = 0;
   localparam int ROW_LSB         = COL_LSB + COORD_BITS;
   localparam int RED_LSB         = ROW_LSB + COORD_BITS;
   localparam int GREEN_LSB       = RED_LSB + PIXEL_BITS;
   localparam int BLUE_LSB        = GREEN_LSB + PIXEL_BITS;
   localparam int LUMA_LSB        = BLUE_LSB + PIXEL_BITS;
   localparam int CHROMA_RED_LSB  = LUMA_LSB + PIXEL_BITS;
   localparam int CHROMA_BLUE_LSB = CHROMA_RED_LSB + PIXEL_BITS;
   localparam int REQ_FIELD_BITS  = CHROMA_BLUE_LSB + PIXEL_BITS;
   localparam int REQ_DATA_BITS   = ((REQ_FIELD_BITS + 7) / 8) * 8;

   localparam int RSP_FIELD_BITS = 6 * BOUND_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   // Gray weights 0.2989, 0.5870 and 0.1140 in unsigned Q16.
   localparam int GRAY_SUM_BITS = 24;
   localparam logic [15:0] RED_WEIGHT   = 16'd19589;
   localparam logic [15:0] GREEN_WEIGHT = 16'd38470;
   localparam logic [15:0] BLUE_WEIGHT  = 16'd7471;
   localparam logic [PIXEL_BITS-1:0] GRAY_LOW  = 8'd40;
   localparam logic [PIXEL_BITS-1:0] GRAY_HIGH = 8'd200;

   localparam logic [2*COORD_BITS-1:0] MIN_AREA = (2*COORD_BITS)'(5);

   localparam logic signed [BOUND_BITS-1:0] HIGH_RESET = -10'sd1;
   localparam logic signed [BOUND_BITS-1:0] LOW_RESET  = 10'sd295;

   localparam logic signed [BOUND_BITS-1:0] DEF_LUMA_MAX = 10'sd255;
   localparam logic signed [BOUND_BITS-1:0] DEF_LUMA_MIN = 10'sd0;
   localparam logic signed [BOUND_BITS-1:0] DEF_CR_MAX   = 10'sd173;
   localparam logic signed [BOUND_BITS-1:0] DEF_CR_MIN   = 10'sd133;
   localparam logic signed [BOUND_BITS-1:0] DEF_CB_MAX   = 10'sd127;
   localparam logic signed [BOUND_BITS-1:0] DEF_CB_MIN   = 10'sd77;

   typedef enum logic [1:0] {
      REG_REGION_LEFT   = 2'd0,
      REG_REGION_TOP    = 2'd1,
      REG_REGION_WIDTH  = 2'd2,
      REG_REGION_HEIGHT = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] region_left;
      logic [COORD_BITS-1:0] region_top;
      logic [COORD_BITS-1:0] region_width;
      logic [COORD_BITS-1:0] region_height;
      logic                  small_area;
   } cfg_type;

   typedef struct packed {
      logic                  valid;
      logic                  last;
      logic                  counted;
      logic [PIXEL_BITS-1:0] luma;
      logic [PIXEL_BITS-1:0] chroma_red;
      logic [PIXEL_BITS-1:0] chroma_blue;
   } stage_type;

endpackage

[rtl/core/strc_csr.sv]
// ----------------------------------------------------------------------------
// strc_csr
// Register file of the face rectangle with its bus port, and the flag that
// marks a rectangle too small to calibrate from.
// ----------------------------------------------------------------------------
module strc_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [strc_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [strc_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [strc_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                 csr_pready,
   output strc_pkg::cfg_type                    cfg
);

   logic [strc_pkg::COORD_BITS-1:0]   left_ff, left_in;
   logic [strc_pkg::COORD_BITS-1:0]   top_ff, top_in;
   logic [strc_pkg::COORD_BITS-1:0]   width_ff, width_in;
   logic [strc_pkg::COORD_BITS-1:0]   height_ff, height_in;
   logic [strc_pkg::COORD_BITS-1:0]   wdata;
   logic [strc_pkg::COORD_BITS-1:0]   rdata;
   logic [2*strc_pkg::COORD_BITS-1:0] area;
   logic                              write_en;
   strc_pkg::reg_index_type           index;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign index      = strc_pkg::reg_index_type'(csr_paddr[3:2]);
   assign wdata      = csr_pwdata[strc_pkg::COORD_BITS-1:0];

   always_comb begin
      left_in   = left_ff;
      top_in    = top_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (write_en) begin
         unique case (index)
            strc_pkg::REG_REGION_LEFT:   left_in   = wdata;
            strc_pkg::REG_REGION_TOP:    top_in    = wdata;
            strc_pkg::REG_REGION_WIDTH:  width_in  = wdata;
            strc_pkg::REG_REGION_HEIGHT: height_in = wdata;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         strc_pkg::REG_REGION_LEFT:   rdata = left_ff;
         strc_pkg::REG_REGION_TOP:    rdata = top_ff;
         strc_pkg::REG_REGION_WIDTH:  rdata = width_ff;
         strc_pkg::REG_REGION_HEIGHT: rdata = height_ff;
      endcase
   end

   assign csr_prdata = strc_pkg::CSR_DATA_BITS'(rdata);

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         top_ff    <= '0;
         width_ff  <= '0;
         height_ff <= '0;
      end else begin
         left_ff   <= left_in;
         top_ff    <= top_in;
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign area = (2*strc_pkg::COORD_BITS)'(width_ff) * (2*strc_pkg::COORD_BITS)'(height_ff);

   assign cfg.region_left   = left_ff;
   assign cfg.region_top    = top_ff;
   assign cfg.region_width  = width_ff;
   assign cfg.region_height = height_ff;
   assign cfg.small_area    = (area <= strc_pkg::MIN_AREA);

endmodule

[rtl/core/strc_qualify.sv]
// ----------------------------------------------------------------------------
// strc_qualify
// Input stage: tests each incoming pixel against the face rectangle, the
// gray window and the red dominance rule, and registers the verdict with
// the pixel's Y, Cr and Cb.
// ----------------------------------------------------------------------------
module strc_qualify (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [strc_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input  logic                               req_tlast,
   input  strc_pkg::cfg_type                  cfg,
   input  logic                               stage_take,
   output strc_pkg::stage_type                stage
);

   logic [strc_pkg::COORD_BITS-1:0]    col;
   logic [strc_pkg::COORD_BITS-1:0]    row;
   logic [strc_pkg::PIXEL_BITS-1:0]    red;
   logic [strc_pkg::PIXEL_BITS-1:0]    green;
   logic [strc_pkg::PIXEL_BITS-1:0]    blue;
   logic [strc_pkg::COORD_BITS:0]      col_end;
   logic [strc_pkg::COORD_BITS:0]      row_end;
   logic [strc_pkg::GRAY_SUM_BITS-1:0] gray_sum;
   logic [strc_pkg::PIXEL_BITS-1:0]    gray;
   logic                               in_rect;
   logic                               counted;
   logic                               load;
   strc_pkg::stage_type                stage_ff, stage_in;

   assign col   = req_tdata[strc_pkg::COL_LSB +: strc_pkg::COORD_BITS];
   assign row   = req_tdata[strc_pkg::ROW_LSB +: strc_pkg::COORD_BITS];
   assign red   = req_tdata[strc_pkg::RED_LSB +: strc_pkg::PIXEL_BITS];
   assign green = req_tdata[strc_pkg::GREEN_LSB +: strc_pkg::PIXEL_BITS];
   assign blue  = req_tdata[strc_pkg::BLUE_LSB +: strc_pkg::PIXEL_BITS];

   assign col_end = {1'b0, cfg.region_left} + {1'b0, cfg.region_width};
   assign row_end = {1'b0, cfg.region_top} + {1'b0, cfg.region_height};
   assign in_rect = (col >= cfg.region_left) && ({1'b0, col} < col_end) &&
                    (row >= cfg.region_top) && ({1'b0, row} < row_end);

   assign gray_sum =
      strc_pkg::GRAY_SUM_BITS'(strc_pkg::RED_WEIGHT) * strc_pkg::GRAY_SUM_BITS'(red) +
      strc_pkg::GRAY_SUM_BITS'(strc_pkg::GREEN_WEIGHT) * strc_pkg::GRAY_SUM_BITS'(green) +
      strc_pkg::GRAY_SUM_BITS'(strc_pkg::BLUE_WEIGHT) * strc_pkg::GRAY_SUM_BITS'(blue);
   assign gray = gray_sum[strc_pkg::GRAY_SUM_BITS-1 -: strc_pkg::PIXEL_BITS];

   assign counted = in_rect && (gray > strc_pkg::GRAY_LOW) && (gray < strc_pkg::GRAY_HIGH) &&
                    (red > green) && (red > blue);

   assign req_tready = !stage_ff.valid || stage_take;
   assign load       = req_tvalid && req_tready;

   always_comb begin
      stage_in = stage_ff;
      if (req_tready) begin
         stage_in.valid = req_tvalid;
      end
      if (load) begin
         stage_in.last        = req_tlast;
         stage_in.counted     = counted;
         stage_in.luma        = req_tdata[strc_pkg::LUMA_LSB +: strc_pkg::PIXEL_BITS];
         stage_in.chroma_red  = req_tdata[strc_pkg::CHROMA_RED_LSB +: strc_pkg::PIXEL_BITS];
         stage_in.chroma_blue = req_tdata[strc_pkg::CHROMA_BLUE_LSB +: strc_pkg::PIXEL_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.last        <= stage_in.last;
      stage_ff.counted     <= stage_in.counted;
      stage_ff.luma        <= stage_in.luma;
      stage_ff.chroma_red  <= stage_in.chroma_red;
      stage_ff.chroma_blue <= stage_in.chroma_blue;
   end

   assign stage = stage_ff;

endmodule

[rtl/core/strc_tracker.sv]
// ----------------------------------------------------------------------------
// strc_tracker
// Running minimum and maximum of Y, Cr and Cb over the counted pixels of a
// frame, and the result register that holds the six bounds for transfer.
// ----------------------------------------------------------------------------
module strc_tracker (
   input  logic                               clock,
   input  logic                               reset,
   input  strc_pkg::stage_type                stage,
   input  logic                               small_area,
   output logic                               stage_take,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [strc_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);

   typedef logic signed [strc_pkg::BOUND_BITS-1:0] bound_type;

   function automatic bound_type widen(input logic [strc_pkg::PIXEL_BITS-1:0] v);
      widen = bound_type'({2'b00, v});
   endfunction

   bound_type luma_high_ff, luma_high_in, luma_low_ff, luma_low_in;
   bound_type crv_high_ff, crv_high_in, crv_low_ff, crv_low_in;
   bound_type cbv_high_ff, cbv_high_in, cbv_low_ff, cbv_low_in;
   bound_type luma_v, cr_v, cb_v;
   bound_type luma_high_upd, luma_low_upd;
   bound_type crv_high_upd, crv_low_upd;
   bound_type cbv_high_upd, cbv_low_upd;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [strc_pkg::RSP_DATA_BITS-1:0]  rsp_data_ff, rsp_data_in;
   logic                                out_free;
   logic                                emit;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign stage_take = stage.valid && (!stage.last || out_free);
   assign emit       = stage_take && stage.last;

   assign luma_v = widen(stage.luma);
   assign cr_v   = widen(stage.chroma_red);
   assign cb_v   = widen(stage.chroma_blue);

   assign luma_high_upd = (stage.counted && luma_v > luma_high_ff) ? luma_v : luma_high_ff;
   assign luma_low_upd  = (stage.counted && luma_v < luma_low_ff)  ? luma_v : luma_low_ff;
   assign crv_high_upd  = (stage.counted && cr_v > crv_high_ff)    ? cr_v   : crv_high_ff;
   assign crv_low_upd   = (stage.counted && cr_v < crv_low_ff)     ? cr_v   : crv_low_ff;
   assign cbv_high_upd  = (stage.counted && cb_v > cbv_high_ff)    ? cb_v   : cbv_high_ff;
   assign cbv_low_upd   = (stage.counted && cb_v < cbv_low_ff)     ? cb_v   : cbv_low_ff;

   always_comb begin
      luma_high_in = luma_high_ff;
      luma_low_in  = luma_low_ff;
      crv_high_in  = crv_high_ff;
      crv_low_in   = crv_low_ff;
      cbv_high_in  = cbv_high_ff;
      cbv_low_in   = cbv_low_ff;
      if (stage_take) begin
         if (stage.last) begin
            luma_high_in = strc_pkg::HIGH_RESET;
            luma_low_in  = strc_pkg::LOW_RESET;
            crv_high_in  = strc_pkg::HIGH_RESET;
            crv_low_in   = strc_pkg::LOW_RESET;
            cbv_high_in  = strc_pkg::HIGH_RESET;
            cbv_low_in   = strc_pkg::LOW_RESET;
         end else begin
            luma_high_in = luma_high_upd;
            luma_low_in  = luma_low_upd;
            crv_high_in  = crv_high_upd;
            crv_low_in   = crv_low_upd;
            cbv_high_in  = cbv_high_upd;
            cbv_low_in   = cbv_low_upd;
         end
      end
   end

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (emit) begin
         rsp_valid_in = 1'b1;
         if (small_area) begin
            rsp_data_in = strc_pkg::RSP_DATA_BITS'({strc_pkg::DEF_CB_MIN, strc_pkg::DEF_CB_MAX,
                                                     strc_pkg::DEF_CR_MIN, strc_pkg::DEF_CR_MAX,
                                                     strc_pkg::DEF_LUMA_MIN,
                                                     strc_pkg::DEF_LUMA_MAX});
         end else begin
            rsp_data_in = strc_pkg::RSP_DATA_BITS'({cbv_low_upd, cbv_high_upd,
                                                     crv_low_upd, crv_high_upd,
                                                     luma_low_upd, luma_high_upd});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         luma_high_ff <= strc_pkg::HIGH_RESET;
         luma_low_ff  <= strc_pkg::LOW_RESET;
         crv_high_ff  <= strc_pkg::HIGH_RESET;
         crv_low_ff   <= strc_pkg::LOW_RESET;
         cbv_high_ff  <= strc_pkg::HIGH_RESET;
         cbv_low_ff   <= strc_pkg::LOW_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         luma_high_ff <= luma_high_in;
         luma_low_ff  <= luma_low_in;
         crv_high_ff  <= crv_high_in;
         crv_low_ff   <= crv_low_in;
         cbv_high_ff  <= cbv_high_in;
         cbv_low_ff   <= cbv_low_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[rtl/core/skin_tone_range_calibrator_unit.sv]
// ----------------------------------------------------------------------------
// skin_tone_range_calibrator_unit
// Learns the Y, Cr and Cb range of skin from the pixels of a face rectangle
// and reports the six bounds once per frame.
// ----------------------------------------------------------------------------
// The unit takes one pixel per clock cycle and never stalls the pixel stream
// while the result channel is free; only the pixel marked as the last of a
// frame waits, and only while the previous result has not been transferred.
// A pixel passes through two registers: the input stage, where the rectangle,
// gray and red tests are made, and the tracker stage, where the bounds are
// updated, and the result is registered when the last pixel of a frame is taken.
// Registers should be written between frames.
// ----------------------------------------------------------------------------
module skin_tone_range_calibrator_unit (
   input  logic                               clock,
   input  logic                               reset,
   // tdata: col, row, red, green, blue, luma, chroma_red, chroma_blue
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [strc_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input  logic                               req_tlast,
   // tdata: luma_max, luma_min, cr_max, cr_min, cb_max, cb_min, zero fill
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [strc_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [strc_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [strc_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [strc_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready
);

   strc_pkg::cfg_type   cfg;
   strc_pkg::stage_type stage;
   logic                stage_take;

   strc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   strc_qualify u_qualify (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .cfg        (cfg),
      .stage_take (stage_take),
      .stage      (stage)
   );

   strc_tracker u_tracker (
      .clock      (clock),
      .reset      (reset),
      .stage      (stage),
      .small_area (cfg.small_area),
      .stage_take (stage_take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(stage_take && stage.last))
      else $error("Result raised without a frame end transfer.");

   assert property (@(posedge clock) disable iff (reset)
      (stage.valid && !stage.last) |-> stage_take)
      else $error("A pixel that is not the frame end was held.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (($signed(rsp_tdata[9:0]) >= $signed(rsp_tdata[19:10])) ||
                      (rsp_tdata[9:0] == 10'h3FF && rsp_tdata[19:10] == 10'd295)))
      else $error("Luma bounds are crossed in a result.");

   assert property (@(posedge clock) disable iff (reset)
      (stage.valid && !stage_take) |-> !req_tready)
      else $error("Input accepted while the stage was held.");

endmodule
